/* hdl/dtad_pkg.sv */
// ----------------------------------------------------------------------------
// dtad_pkg
// shared types, constants and helpers of the table delta audio decoder
// ----------------------------------------------------------------------------
package dtad_pkg;

	localparam int          MAX_CHANNELS_DEF = 2;
	localparam int          POS_W            = 10;
	localparam int          TABLE_BYTES      = 512;
	localparam int          TBL_AW           = 8;
	localparam logic [15:0] ZERO_CODE_BIAS   = 16'd31767;

	// parse phases, other codes act as done
	typedef enum logic [3:0] {
		PH_CHANS  = 4'd0,
		PH_RATE   = 4'd1,
		PH_SKIP_A = 4'd2,
		PH_BLOCKS = 4'd3,
		PH_SKIP_B = 4'd4,
		PH_TABLE  = 4'd5,
		PH_BCOUNT = 4'd6,
		PH_BSKIP  = 4'd7,
		PH_CODES  = 4'd8,
		PH_DONE   = 4'd9
	} phase_t;

	// one code byte handed from the parser to the accumulate stage
	typedef struct packed {
		logic ch;
		logic zero;
		logic lob;
		logic los;
		logic clr;
	} code_req_t;

	function automatic logic [POS_W-1:0] phase_len(input phase_t ph);
		logic [POS_W-1:0] len;
		case (ph)
			PH_CHANS: len = POS_W'(2);
			PH_SKIP_B: len = POS_W'(8);
			PH_TABLE: len = POS_W'(TABLE_BYTES);
			default: len = POS_W'(4);
		endcase
		return len;
	endfunction

endpackage

/* hdl/dtad_table_mem.sv */
// ----------------------------------------------------------------------------
// dtad_table_mem
// delta table storage, one write and one registered read port
// ----------------------------------------------------------------------------
module dtad_table_mem
	import dtad_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [TBL_AW-1:0] waddr,
	input  logic [15:0]       wdata,
	input  logic              re,
	input  logic [TBL_AW-1:0] raddr,
	output logic [15:0]       rdata
);

	logic [15:0] mem [2**TBL_AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/dtad_parser.sv */
// ----------------------------------------------------------------------------
// dtad_parser
// header and block parser, table fill and code request issue
// ----------------------------------------------------------------------------
module dtad_parser
	import dtad_pkg::*;
#(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        data_byte,
	input  logic              start_of_file,
	output logic              code_fire,
	output code_req_t         code_req,
	output logic              tbl_we,
	output logic [TBL_AW-1:0] tbl_waddr,
	output logic [15:0]       tbl_wdata
);

	phase_t           phase_q, phase_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [31:0]      shift_q, shift_d;
	logic             stereo_q, stereo_d;
	logic [31:0]      blocks_q, blocks_d;
	logic [31:0]      codes_q, codes_d;
	logic             cur_q, cur_d;
	logic             first_q, first_d;

	phase_t           ph;
	logic [POS_W-1:0] pos, pos_inc;
	logic [31:0]      fs, fs_new;
	phase_t           after_blk;
	logic             is_code;

	always_comb begin
		ph        = start_of_file ? PH_CHANS : phase_q;
		pos       = start_of_file ? '0 : pos_q;
		fs        = start_of_file ? '0 : shift_q;
		pos_inc   = pos + POS_W'(1);
		after_blk = (blocks_q != '0) ? PH_BCOUNT : PH_DONE;
		is_code   = (ph == PH_CODES);

		phase_d  = ph;
		pos_d    = pos;
		shift_d  = fs;
		stereo_d = stereo_q;
		blocks_d = blocks_q;
		codes_d  = codes_q;
		cur_d    = cur_q;
		first_d  = first_q;

		tbl_we    = 1'b0;
		tbl_waddr = pos[TBL_AW:1];
		tbl_wdata = {data_byte, fs[7:0]};
		fs_new    = fs;

		code_fire    = fire && is_code;
		code_req.ch   = cur_q;
		code_req.zero = (data_byte == 8'd0);
		code_req.lob  = (codes_q == 32'd1);
		code_req.los  = (codes_q == 32'd1) && (blocks_q == '0);
		code_req.clr  = first_q;

		if (is_code) begin
			cur_d   = stereo_q ? ~cur_q : 1'b0;
			codes_d = codes_q - 32'd1;
			first_d = 1'b0;
			if (codes_q == 32'd1) begin
				phase_d = after_blk;
			end
		end else if (ph <= PH_BSKIP) begin
			if (ph == PH_TABLE) begin
				if (pos[0]) begin
					tbl_we = fire;
				end else begin
					fs_new = {24'd0, data_byte};
				end
			end else if (pos < POS_W'(4)) begin
				fs_new = fs | ({24'd0, data_byte} << {pos[1:0], 3'b000});
			end
			shift_d = fs_new;
			pos_d   = pos_inc;
			if (pos_inc >= phase_len(ph)) begin
				pos_d   = '0;
				shift_d = '0;
				case (ph)
					PH_CHANS: begin
						stereo_d = (MAX_CHANNELS >= 2) && !fs_new[15]
							&& (fs_new[15:0] >= 16'd2);
						phase_d = PH_RATE;
					end
					PH_RATE: phase_d = PH_SKIP_A;
					PH_SKIP_A: phase_d = PH_BLOCKS;
					PH_BLOCKS: begin
						blocks_d = fs_new[31] ? '0 : fs_new;
						phase_d  = PH_SKIP_B;
					end
					PH_SKIP_B: phase_d = PH_TABLE;
					PH_TABLE: phase_d = after_blk;
					PH_BCOUNT: begin
						codes_d  = fs_new[31] ? '0 : fs_new;
						blocks_d = blocks_q - 32'd1;
						cur_d    = 1'b0;
						first_d  = 1'b1;
						phase_d  = PH_BSKIP;
					end
					default: begin
						phase_d = (codes_q != '0) ? PH_CODES : after_blk;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_CHANS;
			pos_q    <= '0;
			shift_q  <= '0;
			stereo_q <= 1'b0;
			blocks_q <= '0;
			codes_q  <= '0;
			cur_q    <= 1'b0;
			first_q  <= 1'b0;
		end else if (fire) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			shift_q  <= shift_d;
			stereo_q <= stereo_d;
			blocks_q <= blocks_d;
			codes_q  <= codes_d;
			cur_q    <= cur_d;
			first_q  <= first_d;
		end
	end

endmodule

/* hdl/dtad_accum.sv */
// ----------------------------------------------------------------------------
// dtad_accum
// lookup wait stage, per-channel accumulate and output register
// ----------------------------------------------------------------------------
module dtad_accum
	import dtad_pkg::*;
#(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               code_fire,
	input  code_req_t          code_req,
	input  logic [15:0]        rdata,
	output logic               take_ok,
	output logic               sample_valid,
	input  logic               sample_ready,
	output logic signed [15:0] sample,
	output logic               channel,
	output logic               last_of_block,
	output logic               last_of_stream
);

	logic        v_s1;
	code_req_t   req_s1;
	logic [15:0] acc_q [MAX_CHANNELS];
	logic        advance, move;
	logic [15:0] acc_sel, sum;

	assign advance = !sample_valid || sample_ready;
	assign take_ok = !v_s1 || advance;
	assign move    = v_s1 && advance;

	always_comb begin
		acc_sel = '0;
		for (int i = 0; i < MAX_CHANNELS; i++) begin
			if (req_s1.ch == 1'(i)) begin
				acc_sel = acc_q[i];
			end
		end
		sum = (req_s1.clr ? 16'd0 : acc_sel) + rdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (code_fire) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (code_fire) begin
			req_s1 <= code_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				acc_q[i] <= '0;
			end
		end else if (move) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				if (req_s1.ch == 1'(i)) begin
					acc_q[i] <= sum;
				end else if (req_s1.clr) begin
					acc_q[i] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else if (move) begin
			sample_valid <= 1'b1;
		end else if (sample_ready) begin
			sample_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			sample         <= req_s1.zero ? (sum - ZERO_CODE_BIAS) : sum;
			channel        <= req_s1.ch;
			last_of_block  <= req_s1.lob;
			last_of_stream <= req_s1.los;
		end
	end

endmodule

/* hdl/table_delta_audio_stream_decoder.sv */
// ----------------------------------------------------------------------------
// table_delta_audio_stream_decoder
// byte stream in, decoded delta audio samples out
// ----------------------------------------------------------------------------
// the input channel takes one file byte per request (data_valid/data_ready),
// start_of_file marks the first byte of a new file. header bytes fill the
// 256 x 16 delta table memory, code bytes each make one sample request on
// the output channel (sample_valid/sample_ready) with its channel and
// end-of-block / end-of-stream marks. other bytes make no request.
// path: a code byte accepted reads the table memory into the lookup stage,
// then the accumulate stage adds and loads the output register.
// throughput: one byte per cycle, set by the single table read port and the
// one accumulate stage; both sides run at full rate when nothing stalls.
// stall: with the output register full and the receiver stalled, one more
// code byte may wait in the lookup stage; data_ready then drops until the
// output moves.
// reset: parsing restarts at the channel-count field, accumulators, counts
// and the pipeline clear; the table contents are kept undefined until a
// header rewrites them, no clearing pass is needed.
// ----------------------------------------------------------------------------
module table_delta_audio_stream_decoder
	import dtad_pkg::*;
#(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               data_valid,
	output logic               data_ready,
	input  logic [7:0]         data_byte,
	input  logic               start_of_file,
	output logic               sample_valid,
	input  logic               sample_ready,
	output logic signed [15:0] sample,
	output logic               channel,
	output logic               last_of_block,
	output logic               last_of_stream
);

	logic              fire;
	logic              code_fire;
	code_req_t         code_req;
	logic              tbl_we;
	logic [TBL_AW-1:0] tbl_waddr;
	logic [15:0]       tbl_wdata;
	logic [15:0]       tbl_rdata;
	logic              take_ok;

	// a byte request completes when both sides agree
	assign data_ready = take_ok;
	assign fire       = data_valid && data_ready;

	// parser: field assembly, counts, channel toggle, table writes
	dtad_parser #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.data_byte    (data_byte),
		.start_of_file(start_of_file),
		.code_fire    (code_fire),
		.code_req     (code_req),
		.tbl_we       (tbl_we),
		.tbl_waddr    (tbl_waddr),
		.tbl_wdata    (tbl_wdata)
	);

	// code byte itself addresses the delta table
	dtad_table_mem u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(tbl_waddr),
		.wdata(tbl_wdata),
		.re   (code_fire),
		.raddr(data_byte),
		.rdata(tbl_rdata)
	);

	// accumulate stage and output register
	dtad_accum #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.code_fire     (code_fire),
		.code_req      (code_req),
		.rdata         (tbl_rdata),
		.take_ok       (take_ok),
		.sample_valid  (sample_valid),
		.sample_ready  (sample_ready),
		.sample        (sample),
		.channel       (channel),
		.last_of_block (last_of_block),
		.last_of_stream(last_of_stream)
	);

endmodule
